### hw/rtl/nbody_gravity_spring_step_macros.svh
// assertion macros used by the top-level rtl file
// no dependencies; define ASSERT_OFF to drop every check
`ifndef NBODY_GRAVITY_SPRING_STEP_MACROS_SVH
`define NBODY_GRAVITY_SPRING_STEP_MACROS_SVH
`ifndef ASSERT_OFF
// same-cycle implication
`define NGS_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("ngs assertion failed");
// next-cycle implication
`define NGS_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("ngs assertion failed");
`else
`define NGS_ASSERT_IMP(label, clk, rstn, ante, cons)
`define NGS_ASSERT_NXT(label, clk, rstn, ante, cons)
`endif
`endif

### hw/rtl/ngs_pkg.sv
// shared types, codes and arithmetic helpers of the n-body step block
// no dependencies
package ngs_pkg;

    localparam int MAX_BODIES = 64;
    localparam int IDX_W      = $clog2(MAX_BODIES);
    localparam int CNT_W      = $clog2(MAX_BODIES + 1);

    // long divider geometry: 68-bit dividend, 64-bit divisor
    localparam int DIV_NW   = 68;
    localparam int DIV_DW   = 64;
    localparam int DIV_CW   = $clog2(DIV_NW + 1);

    localparam logic [19:0] GRAVITY_RESET  = 20'd10000;
    localparam logic [7:0]  SPRING_RESET   = 8'd10;
    localparam logic [16:0] FRICTION_RESET = 17'd6554;
    localparam logic [9:0]  CONTACT_RESET  = 10'd40;

    typedef enum logic [1:0] {
        ACT_ADD   = 2'd0,
        ACT_STEP  = 2'd1,
        ACT_CLEAR = 2'd2
    } ngs_action_t;

    typedef enum logic [2:0] {
        STAT_BODY    = 3'd0,
        STAT_ADDED   = 3'd1,
        STAT_FULL    = 3'd2,
        STAT_CLEARED = 3'd3,
        STAT_EMPTY   = 3'd4
    } ngs_status_t;

    typedef enum logic [2:0] {
        CFG_CENTER_X = 3'd0,
        CFG_CENTER_Y = 3'd1,
        CFG_GRAVITY  = 3'd2,
        CFG_SPRING   = 3'd3,
        CFG_FRICTION = 3'd4,
        CFG_CONTACT  = 3'd5
    } ngs_cfg_idx_t;

    typedef enum logic [5:0] {
        S_IDLE, S_RESP,
        S_RD_I, S_LD_I, S_RD_J, S_LD_J,
        S_DIFF, S_MUL_X, S_MUL_Y, S_SUM, S_CHK, S_WAIT_B,
        S_MUL_GX, S_DIV_GX, S_WAIT_GX, S_MUL_GY, S_DIV_GY, S_WAIT_GY, S_APPLY_G,
        S_MUL_K, S_MUL_SX, S_DIV_SX, S_WAIT_SX, S_MUL_SY, S_DIV_SY, S_WAIT_SY,
        S_APPLY_S, S_FR_IX, S_FR_IY, S_FR_JX, S_FR_JY, S_FR_END,
        S_PAIR_END, S_WB_I, S_PRD, S_PUPD, S_PEMIT
    } ngs_state_t;

    // status of an iterative arithmetic unit
    typedef struct packed {
        logic busy;
        logic done;
    } ngs_unit_st_t;

    // clamp a wide signed value to the signed 32-bit range
    function automatic logic signed [31:0] sat32(input logic signed [37:0] v);
        logic signed [31:0] r;
        if (v > 38'sd2147483647) begin
            r = 32'sh7FFFFFFF;
        end else if (v < -38'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    // friction: floor(product / 2^16) then clamp
    function automatic logic signed [31:0] fric(input logic signed [71:0] p);
        return sat32($signed(p[53:16]));
    endfunction

endpackage

### hw/rtl/ngs_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
module ngs_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### hw/rtl/ngs_sqrt.sv
// iterative integer square root, one result bit per cycle
// depends on ngs_pkg
module ngs_sqrt import ngs_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         start,
    input  logic [63:0]  radicand,
    output ngs_unit_st_t st,
    output logic [31:0]  root
);

    logic [63:0] n_reg, r_reg, bit_reg;
    logic        busy_reg, done_reg;
    logic [63:0] trial;
    logic [63:0] bit_next;

    assign trial    = r_reg + bit_reg;
    assign bit_next = bit_reg >> 2;

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else if (start) begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end else if (busy_reg && bit_next == 64'd0) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b1;
        end
    end

    // digit-by-digit root
    always_ff @(posedge aclk) begin
        if (start) begin
            n_reg   <= radicand;
            r_reg   <= 64'd0;
            bit_reg <= 64'd1 << 62;
        end else if (busy_reg) begin
            if (n_reg >= trial) begin
                n_reg <= n_reg - trial;
                r_reg <= (r_reg >> 1) + bit_reg;
            end else begin
                r_reg <= r_reg >> 1;
            end
            bit_reg <= bit_next;
        end
    end

    assign st   = '{busy: busy_reg, done: done_reg};
    assign root = r_reg[31:0];

endmodule

### hw/rtl/ngs_div.sv
// restoring unsigned divider, one quotient bit per cycle
// depends on ngs_pkg
module ngs_div import ngs_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [DIV_NW-1:0] dividend,
    input  logic [DIV_DW-1:0] divisor,
    output ngs_unit_st_t      st,
    output logic [DIV_NW-1:0] quotient
);

    logic [DIV_NW-1:0] quo_reg;
    logic [DIV_DW-1:0] rem_reg, dvs_reg;
    logic [DIV_CW-1:0] cnt_reg;
    logic              busy_reg, done_reg;
    logic [DIV_DW:0]   trial;
    logic              fits;

    assign trial = {rem_reg, quo_reg[DIV_NW-1]};
    assign fits  = trial >= {1'b0, dvs_reg};

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= DIV_CW'(DIV_NW);
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == DIV_CW'(1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    // shift dividend bits out into the remainder, shift quotient bits in
    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end else if (busy_reg) begin
            rem_reg <= fits ? DIV_DW'(trial - {1'b0, dvs_reg}) : trial[DIV_DW-1:0];
            quo_reg <= {quo_reg[DIV_NW-2:0], fits};
        end
    end

    assign st       = '{busy: busy_reg, done: done_reg};
    assign quotient = quo_reg;

endmodule

### hw/rtl/nbody_gravity_spring_step.sv
// top level of the n-body step block: sequencer, datapath and body memories
// depends on ngs_pkg, ngs_ram, ngs_sqrt, ngs_div and the macros header
//
// Usage. Items arrive on the s_ channel (valid/ready). Action add appends one
// body and answers status added (or store full), clear empties the store,
// step runs one frame and reports every body's new position on the m_ channel,
// one transfer per body in index order, m_last on the final one (status
// empty if no body is stored). An unknown action is dropped without a result.
// Bodies live in two rams (position and velocity, {x,y} per word). A frame
// visits the central mass and then each later body for every body i; each
// visit runs a square root alongside a divide, then two more divides, or
// four when the contact spring acts; a pair at zero distance skips them.
// A frame of n bodies takes roughly n*(n+1)/2 visits plus, per body, a
// velocity write-back and a position pass (read, update and emit states).
// The divider sets the pace. Reset empties the store and loads the
// register defaults; the rams are not cleared. A stalled receiver holds
// the output register and the sequencer waits; the next item is taken
// once the sequencer is idle again.
`include "nbody_gravity_spring_step_macros.svh"
module nbody_gravity_spring_step import ngs_pkg::*; (
    input  logic                     aclk,
    input  logic                     aresetn,
    // configuration
    input  logic                     cfg_we,
    input  logic [2:0]               cfg_index,
    input  logic [19:0]              cfg_wdata,
    // items in
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [1:0]               s_action,
    input  logic signed [31:0]       s_new_pos_x,
    input  logic signed [31:0]       s_new_pos_y,
    input  logic signed [31:0]       s_new_vel_x,
    input  logic signed [31:0]       s_new_vel_y,
    // results out
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [2:0]               m_status,
    output logic [IDX_W-1:0]         m_body_index,
    output logic signed [31:0]       m_pos_x,
    output logic signed [31:0]       m_pos_y,
    output logic                     m_last
);

    ngs_state_t state_reg, state_next;

    // configuration registers
    logic [15:0] center_x_reg, center_y_reg;
    logic [19:0] gravity_reg;
    logic [7:0]  spring_reg;
    logic [16:0] friction_reg;
    logic [9:0]  contact_reg;

    logic [CNT_W-1:0] count_reg, i_reg, j_reg;
    logic [CNT_W-1:0] i_inc, j_inc;

    // working set
    logic signed [31:0] pi_x_reg, pi_y_reg, vi_x_reg, vi_y_reg;
    logic signed [31:0] pj_x_reg, pj_y_reg, vj_x_reg, vj_y_reg;
    logic signed [31:0] dx_reg, dy_reg, gx_reg, gy_reg;
    logic signed [35:0] sx_reg, sy_reg;
    logic [63:0]        d2_reg;
    logic [31:0]        dist_reg;
    logic [30:0]        b_reg;
    logic [33:0]        k_reg;
    logic               pair_mode_reg;
    logic signed [71:0] prod_reg;

    // pending single response
    logic [2:0]         resp_status_reg;
    logic [IDX_W-1:0]   resp_index_reg;
    logic signed [31:0] resp_px_reg, resp_py_reg;
    logic               resp_last_reg;

    logic               m_valid_reg;

    // handshake and control
    logic               in_acc, out_free, out_load, is_full;
    logic               div_start, sqrt_start;
    logic [DIV_NW-1:0]  div_n;
    logic [DIV_DW-1:0]  div_d;
    logic [DIV_NW-1:0]  div_q;
    logic [31:0]        sqrt_root;
    ngs_unit_st_t       div_st, sqrt_st;
    logic signed [35:0] mul_a, mul_b;

    // memory ports
    logic               pos_we, vel_we;
    logic [IDX_W-1:0]   pos_waddr, vel_waddr, rd_addr;
    logic [63:0]        pos_wdata, vel_wdata, pos_rdata, vel_rdata;

    // derived values
    logic signed [32:0] bx, by;
    logic [31:0]        dx_mag, dy_mag;
    logic [25:0]        cq, cq_gap;
    logic [31:0]        q32;
    logic [35:0]        q36;
    logic signed [31:0] new_px, new_py;

    assign in_acc   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign is_full  = count_reg >= CNT_W'(MAX_BODIES);
    assign i_inc    = i_reg + 1'b1;
    assign j_inc    = j_reg + 1'b1;

    assign bx = pair_mode_reg ? {pj_x_reg[31], pj_x_reg} : {1'b0, center_x_reg, 16'd0};
    assign by = pair_mode_reg ? {pj_y_reg[31], pj_y_reg} : {1'b0, center_y_reg, 16'd0};
    assign dx_mag = dx_reg[31] ? (~dx_reg + 32'd1) : dx_reg;
    assign dy_mag = dy_reg[31] ? (~dy_reg + 32'd1) : dy_reg;
    assign cq     = {contact_reg, 16'd0};
    assign cq_gap = cq - dist_reg[25:0];
    assign q32    = div_q[31:0];
    assign q36    = div_q[35:0];
    assign new_px = pos_rdata[63:32] + vel_rdata[63:32];
    assign new_py = pos_rdata[31:0] + vel_rdata[31:0];

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (in_acc) begin
                    case (s_action)
                        ACT_ADD:   state_next = S_RESP;
                        ACT_CLEAR: state_next = S_RESP;
                        ACT_STEP:  state_next = (count_reg == '0) ? S_RESP : S_RD_I;
                        default:   state_next = S_IDLE;
                    endcase
                end
            end
            S_RESP:     if (out_free) state_next = S_IDLE;
            S_RD_I:     state_next = S_LD_I;
            S_LD_I:     state_next = S_DIFF;
            S_RD_J:     state_next = S_LD_J;
            S_LD_J:     state_next = S_DIFF;
            S_DIFF:     state_next = S_MUL_X;
            S_MUL_X:    state_next = S_MUL_Y;
            S_MUL_Y:    state_next = S_SUM;
            S_SUM:      state_next = S_CHK;
            S_CHK:      state_next = (d2_reg == 64'd0) ? S_PAIR_END : S_WAIT_B;
            S_WAIT_B:   if (div_st.done && sqrt_st.done) state_next = S_MUL_GX;
            S_MUL_GX:   state_next = S_DIV_GX;
            S_DIV_GX:   state_next = S_WAIT_GX;
            S_WAIT_GX:  if (div_st.done) state_next = S_MUL_GY;
            S_MUL_GY:   state_next = S_DIV_GY;
            S_DIV_GY:   state_next = S_WAIT_GY;
            S_WAIT_GY:  if (div_st.done) state_next = S_APPLY_G;
            S_APPLY_G:  state_next = (dist_reg >= {6'd0, cq}) ? S_PAIR_END : S_MUL_K;
            S_MUL_K:    state_next = S_MUL_SX;
            S_MUL_SX:   state_next = S_DIV_SX;
            S_DIV_SX:   state_next = S_WAIT_SX;
            S_WAIT_SX:  if (div_st.done) state_next = S_MUL_SY;
            S_MUL_SY:   state_next = S_DIV_SY;
            S_DIV_SY:   state_next = S_WAIT_SY;
            S_WAIT_SY:  if (div_st.done) state_next = S_APPLY_S;
            S_APPLY_S:  state_next = S_FR_IX;
            S_FR_IX:    state_next = S_FR_IY;
            S_FR_IY:    state_next = S_FR_JX;
            S_FR_JX:    state_next = S_FR_JY;
            S_FR_JY:    state_next = S_FR_END;
            S_FR_END:   state_next = S_PAIR_END;
            S_PAIR_END: begin
                if (pair_mode_reg) begin
                    state_next = (j_inc < count_reg) ? S_RD_J : S_WB_I;
                end else begin
                    state_next = (i_inc < count_reg) ? S_RD_J : S_WB_I;
                end
            end
            S_WB_I:     state_next = (i_inc < count_reg) ? S_RD_I : S_PRD;
            S_PRD:      state_next = S_PUPD;
            S_PUPD:     state_next = S_PEMIT;
            S_PEMIT: begin
                if (out_free) begin
                    state_next = (i_inc == count_reg) ? S_IDLE : S_PRD;
                end
            end
            default:    state_next = S_IDLE;
        endcase
    end

    // control outputs: handshake, memory ports, unit starts, multiplier operands
    always_comb begin
        s_ready    = 1'b0;
        out_load   = 1'b0;
        div_start  = 1'b0;
        sqrt_start = 1'b0;
        div_n      = {4'd0, prod_reg[63:0]};
        div_d      = {32'd0, dist_reg};
        mul_a      = '0;
        mul_b      = '0;
        pos_we     = 1'b0;
        vel_we     = 1'b0;
        pos_waddr  = i_reg[IDX_W-1:0];
        vel_waddr  = i_reg[IDX_W-1:0];
        pos_wdata  = {new_px, new_py};
        vel_wdata  = {vi_x_reg, vi_y_reg};
        rd_addr    = (state_reg == S_RD_J) ? j_reg[IDX_W-1:0] : i_reg[IDX_W-1:0];
        case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (in_acc && s_action == ACT_ADD && !is_full) begin
                    pos_we    = 1'b1;
                    vel_we    = 1'b1;
                    pos_waddr = count_reg[IDX_W-1:0];
                    vel_waddr = count_reg[IDX_W-1:0];
                    pos_wdata = {s_new_pos_x, s_new_pos_y};
                    vel_wdata = {s_new_vel_x, s_new_vel_y};
                end
            end
            S_RESP:  out_load = out_free;
            S_PEMIT: out_load = out_free;
            S_MUL_X: begin
                mul_a = {{4{dx_reg[31]}}, dx_reg};
                mul_b = {{4{dx_reg[31]}}, dx_reg};
            end
            S_MUL_Y: begin
                mul_a = {{4{dy_reg[31]}}, dy_reg};
                mul_b = {{4{dy_reg[31]}}, dy_reg};
            end
            S_CHK: begin
                if (d2_reg != 64'd0) begin
                    div_start  = 1'b1;
                    sqrt_start = 1'b1;
                    div_n      = {gravity_reg, 48'd0};
                    div_d      = d2_reg;
                end
            end
            S_MUL_GX: begin
                mul_a = {4'd0, dx_mag};
                mul_b = {5'd0, b_reg};
            end
            S_MUL_GY: begin
                mul_a = {4'd0, dy_mag};
                mul_b = {5'd0, b_reg};
            end
            S_DIV_GX, S_DIV_GY, S_DIV_SX, S_DIV_SY: div_start = 1'b1;
            S_MUL_K: begin
                mul_a = {10'd0, cq_gap};
                mul_b = {28'd0, spring_reg};
            end
            S_MUL_SX: begin
                mul_a = {4'd0, dx_mag};
                mul_b = {2'd0, prod_reg[33:0]};
            end
            S_MUL_SY: begin
                mul_a = {4'd0, dy_mag};
                mul_b = {2'd0, k_reg};
            end
            S_FR_IX: begin
                mul_a = {{4{vi_x_reg[31]}}, vi_x_reg};
                mul_b = {19'd0, friction_reg};
            end
            S_FR_IY: begin
                mul_a = {{4{vi_y_reg[31]}}, vi_y_reg};
                mul_b = {19'd0, friction_reg};
            end
            S_FR_JX: begin
                mul_a = {{4{vj_x_reg[31]}}, vj_x_reg};
                mul_b = {19'd0, friction_reg};
            end
            S_FR_JY: begin
                mul_a = {{4{vj_y_reg[31]}}, vj_y_reg};
                mul_b = {19'd0, friction_reg};
            end
            S_PAIR_END: begin
                vel_we    = pair_mode_reg;
                vel_waddr = j_reg[IDX_W-1:0];
                vel_wdata = {vj_x_reg, vj_y_reg};
            end
            S_WB_I:  vel_we = 1'b1;
            S_PUPD:  pos_we = 1'b1;
            default: ;
        endcase
    end

    // sequencer, counters, configuration and output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            i_reg        <= '0;
            j_reg        <= '0;
            m_valid_reg  <= 1'b0;
            center_x_reg <= '0;
            center_y_reg <= '0;
            gravity_reg  <= GRAVITY_RESET;
            spring_reg   <= SPRING_RESET;
            friction_reg <= FRICTION_RESET;
            contact_reg  <= CONTACT_RESET;
        end else begin
            state_reg <= state_next;
            if (cfg_we) begin
                case (cfg_index)
                    CFG_CENTER_X: center_x_reg <= cfg_wdata[15:0];
                    CFG_CENTER_Y: center_y_reg <= cfg_wdata[15:0];
                    CFG_GRAVITY:  gravity_reg  <= cfg_wdata;
                    CFG_SPRING:   spring_reg   <= cfg_wdata[7:0];
                    CFG_FRICTION: friction_reg <= cfg_wdata[16:0];
                    CFG_CONTACT:  contact_reg  <= cfg_wdata[9:0];
                    default: ;
                endcase
            end
            if (state_reg == S_IDLE && in_acc) begin
                i_reg <= '0;
                if (s_action == ACT_ADD && !is_full) begin
                    count_reg <= count_reg + 1'b1;
                end else if (s_action == ACT_CLEAR) begin
                    count_reg <= '0;
                end
            end
            if (state_reg == S_PAIR_END) begin
                j_reg <= pair_mode_reg ? j_inc : i_inc;
            end
            if (state_reg == S_WB_I) begin
                i_reg <= (i_inc < count_reg) ? i_inc : '0;
            end
            if (state_reg == S_PEMIT && out_free) begin
                i_reg <= i_inc;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // shared multiplier, registered
    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        case (state_reg)
            S_IDLE: begin
                if (in_acc) begin
                    resp_index_reg <= '0;
                    resp_px_reg    <= '0;
                    resp_py_reg    <= '0;
                    resp_last_reg  <= 1'b1;
                    case (s_action)
                        ACT_ADD: begin
                            if (is_full) begin
                                resp_status_reg <= STAT_FULL;
                            end else begin
                                resp_status_reg <= STAT_ADDED;
                                resp_index_reg  <= count_reg[IDX_W-1:0];
                                resp_px_reg     <= s_new_pos_x;
                                resp_py_reg     <= s_new_pos_y;
                            end
                        end
                        ACT_CLEAR: resp_status_reg <= STAT_CLEARED;
                        default:   resp_status_reg <= STAT_EMPTY;
                    endcase
                end
            end
            S_LD_I: begin
                pi_x_reg      <= pos_rdata[63:32];
                pi_y_reg      <= pos_rdata[31:0];
                vi_x_reg      <= vel_rdata[63:32];
                vi_y_reg      <= vel_rdata[31:0];
                pair_mode_reg <= 1'b0;
            end
            S_LD_J: begin
                pj_x_reg      <= pos_rdata[63:32];
                pj_y_reg      <= pos_rdata[31:0];
                vj_x_reg      <= vel_rdata[63:32];
                vj_y_reg      <= vel_rdata[31:0];
                pair_mode_reg <= 1'b1;
            end
            S_DIFF: begin
                dx_reg <= sat32({{5{bx[32]}}, bx} - {{6{pi_x_reg[31]}}, pi_x_reg});
                dy_reg <= sat32({{5{by[32]}}, by} - {{6{pi_y_reg[31]}}, pi_y_reg});
            end
            S_MUL_Y: d2_reg <= prod_reg[63:0];
            S_SUM:   d2_reg <= d2_reg + prod_reg[63:0];
            S_WAIT_B: begin
                dist_reg <= sqrt_root;
                b_reg    <= (|div_q[DIV_NW-1:31]) ? 31'h7FFFFFFF : div_q[30:0];
            end
            S_WAIT_GX: gx_reg <= dx_reg[31] ? (~q32 + 32'd1) : q32;
            S_WAIT_GY: gy_reg <= dy_reg[31] ? (~q32 + 32'd1) : q32;
            S_APPLY_G: begin
                vi_x_reg <= sat32({{6{vi_x_reg[31]}}, vi_x_reg} + {{6{gx_reg[31]}}, gx_reg});
                vi_y_reg <= sat32({{6{vi_y_reg[31]}}, vi_y_reg} + {{6{gy_reg[31]}}, gy_reg});
                vj_x_reg <= sat32({{6{vj_x_reg[31]}}, vj_x_reg} - {{6{gx_reg[31]}}, gx_reg});
                vj_y_reg <= sat32({{6{vj_y_reg[31]}}, vj_y_reg} - {{6{gy_reg[31]}}, gy_reg});
            end
            S_MUL_SX:  k_reg  <= prod_reg[33:0];
            S_WAIT_SX: sx_reg <= dx_reg[31] ? (~q36 + 36'd1) : q36;
            S_WAIT_SY: sy_reg <= dy_reg[31] ? (~q36 + 36'd1) : q36;
            S_APPLY_S: begin
                vi_x_reg <= sat32({{6{vi_x_reg[31]}}, vi_x_reg} - {{2{sx_reg[35]}}, sx_reg});
                vi_y_reg <= sat32({{6{vi_y_reg[31]}}, vi_y_reg} - {{2{sy_reg[35]}}, sy_reg});
                vj_x_reg <= sat32({{6{vj_x_reg[31]}}, vj_x_reg} + {{2{sx_reg[35]}}, sx_reg});
                vj_y_reg <= sat32({{6{vj_y_reg[31]}}, vj_y_reg} + {{2{sy_reg[35]}}, sy_reg});
            end
            S_FR_IY:  vi_x_reg <= fric(prod_reg);
            S_FR_JX:  vi_y_reg <= fric(prod_reg);
            S_FR_JY:  vj_x_reg <= fric(prod_reg);
            S_FR_END: vj_y_reg <= fric(prod_reg);
            S_PUPD: begin
                resp_status_reg <= STAT_BODY;
                resp_index_reg  <= i_reg[IDX_W-1:0];
                resp_px_reg     <= new_px;
                resp_py_reg     <= new_py;
                resp_last_reg   <= (i_inc == count_reg);
            end
            default: ;
        endcase
    end

    // output register
    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_status     <= resp_status_reg;
            m_body_index <= resp_index_reg;
            m_pos_x      <= resp_px_reg;
            m_pos_y      <= resp_py_reg;
            m_last       <= resp_last_reg;
        end
    end

    assign m_valid = m_valid_reg;

    // body memories: a write and a read can meet on one entry in one cycle; the read then returns the old word
    ngs_ram #(.WIDTH(64), .DEPTH(MAX_BODIES)) u_pos_ram (
        .aclk  (aclk),
        .we    (pos_we),
        .waddr (pos_waddr),
        .wdata (pos_wdata),
        .raddr (rd_addr),
        .rdata (pos_rdata)
    );

    ngs_ram #(.WIDTH(64), .DEPTH(MAX_BODIES)) u_vel_ram (
        .aclk  (aclk),
        .we    (vel_we),
        .waddr (vel_waddr),
        .wdata (vel_wdata),
        .raddr (rd_addr),
        .rdata (vel_rdata)
    );

    // arithmetic units
    ngs_sqrt u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (sqrt_start),
        .radicand (d2_reg),
        .st       (sqrt_st),
        .root     (sqrt_root)
    );

    ngs_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_n),
        .divisor  (div_d),
        .st       (div_st),
        .quotient (div_q)
    );

    // checks
    `NGS_ASSERT_IMP(a_div_start_idle, aclk, aresetn, div_start, !div_st.busy)
    `NGS_ASSERT_IMP(a_out_slot_free, aclk, aresetn, out_load, !m_valid_reg || m_ready)
    `NGS_ASSERT_IMP(a_root_before_quot, aclk, aresetn, state_reg == S_WAIT_B && div_st.done, sqrt_st.done)
    `NGS_ASSERT_NXT(a_add_counts, aclk, aresetn, in_acc && s_action == ACT_ADD && !is_full, count_reg == CNT_W'($past(count_reg) + 1'b1))

endmodule
